/* sv/cslru_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cslru_pkg
// Shared sizes, codes and types of the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package cslru_pkg;

    // Store geometry
    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int NUM_SETS     = 1 << MAX_SET_BITS;
    localparam int SET_IDX_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_IDX_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W       = WAY_IDX_W;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

    // Field widths
    localparam int ADDR_W       = 64;
    localparam int TAG_W        = 64;
    localparam int SHAMT_W      = 7;
    localparam int KIND_W       = 2;
    localparam int OUTCOME_W    = 2;
    localparam int COUNT_W      = 32;
    localparam int SET_BITS_W   = 3;
    localparam int BLOCK_BITS_W = 6;
    localparam int WAYS_W       = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD,
        KIND_STORE,
        KIND_MODIFY,
        KIND_IGNORE
    } t_kind;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_HIT,
        OUT_MISS,
        OUT_EVICT,
        OUT_IGNORED
    } t_outcome;

    // One way of a set
    typedef struct packed {
        logic              vld;
        logic [TAG_W-1:0]  tag;
        logic [RANK_W-1:0] rank;
    } t_way;

    // One set: all its ways side by side
    typedef t_way [MAX_WAYS-1:0] t_row;

    // Lookup verdict handed from the way logic to the top level
    typedef struct packed {
        t_outcome outcome;
        logic     second_hit;
        logic     wr_en;
    } t_lookup;

endpackage

`default_nettype wire

/* sv/cslru_addr_split.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cslru_addr_split
// Splits a byte address into set index and tag under the current geometry.
// ----------------------------------------------------------------------------
module cslru_addr_split (
    input  wire logic [cslru_pkg::ADDR_W-1:0]       i_address,
    input  wire logic [cslru_pkg::SET_BITS_W-1:0]   i_set_bits,
    input  wire logic [cslru_pkg::BLOCK_BITS_W-1:0] i_block_bits,
    output logic      [cslru_pkg::SET_IDX_W-1:0]    o_set,
    output logic      [cslru_pkg::TAG_W-1:0]        o_tag
);
    import cslru_pkg::*;

    logic [SHAMT_W-1:0]   sb;
    logic [SHAMT_W-1:0]   bb;
    logic [SHAMT_W-1:0]   bb_lim;
    logic [SHAMT_W-1:0]   shamt;
    logic [ADDR_W-1:0]    off;
    logic [SET_IDX_W-1:0] set_mask;

    // Clamp set bits, then clamp block bits so both fit in the address
    always_comb begin
        sb     = (int'(i_set_bits) > MAX_SET_BITS) ? SHAMT_W'(MAX_SET_BITS)
                                                   : SHAMT_W'(i_set_bits);
        bb_lim = SHAMT_W'(ADDR_W) - sb;
        bb     = (SHAMT_W'(i_block_bits) > bb_lim) ? bb_lim : SHAMT_W'(i_block_bits);
        shamt  = sb + bb;
    end

    // Shifts of the full width or more give zero
    assign off   = i_address >> bb;
    assign o_tag = i_address >> shamt;

    // Keep only the low set bits of the shifted address
    always_comb begin
        for (int i = 0; i < SET_IDX_W; i++) begin
            set_mask[i] = (i < int'(sb));
        end
    end

    assign o_set = off[SET_IDX_W-1:0] & set_mask;

endmodule

`default_nettype wire

/* sv/cslru_set_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cslru_set_store
// Row memory of the cache, one row per set, with row valid bits and bypass.
// ----------------------------------------------------------------------------
module cslru_set_store (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_rd_en,
    input  wire logic [cslru_pkg::SET_IDX_W-1:0] i_rd_set,
    input  wire logic                            i_wr_en,
    input  wire logic [cslru_pkg::SET_IDX_W-1:0] i_wr_set,
    input  wire cslru_pkg::t_row                 i_wr_row,
    output cslru_pkg::t_row                      o_row
);
    import cslru_pkg::*;

    t_row                r_mem [NUM_SETS];
    t_row                r_rd_row;
    t_row                r_byp_row;
    logic                r_byp;
    logic                r_rd_rvld;
    logic [NUM_SETS-1:0] r_row_vld;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_set] <= i_wr_row;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_row <= r_mem[i_rd_set];
        end
    end

    // Row valid bits: a row never written reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_wr_en) begin
            r_row_vld[i_wr_set] <= 1'b1;
        end
    end

    // Capture a write to the same row in the read cycle, and the row's valid bit
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_rvld <= r_row_vld[i_rd_set];
            r_byp     <= i_wr_en && (i_wr_set == i_rd_set);
            r_byp_row <= i_wr_row;
        end
    end

    assign o_row = r_byp     ? r_byp_row :
                   r_rd_rvld ? r_rd_row  : '0;

endmodule

`default_nettype wire

/* sv/cslru_way_logic.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cslru_way_logic
// Parallel tag compare over one set, LRU victim choice and rank update.
// ----------------------------------------------------------------------------
module cslru_way_logic (
    input  wire cslru_pkg::t_row                  i_row,
    input  wire logic [cslru_pkg::TAG_W-1:0]      i_tag,
    input  wire logic [cslru_pkg::WAYS_W-1:0]     i_ways,
    input  wire cslru_pkg::t_kind                 i_kind,
    output cslru_pkg::t_row                       o_row,
    output cslru_pkg::t_lookup                    o_res
);
    import cslru_pkg::*;

    logic [MAX_WAYS-1:0]  in_use;
    logic [MAX_WAYS-1:0]  match;
    logic [MAX_WAYS-1:0]  free;
    logic                 any_hit;
    logic                 any_free;
    logic [WAY_IDX_W-1:0] hit_w;
    logic [WAY_IDX_W-1:0] free_w;
    logic [WAY_IDX_W-1:0] vic_w;
    logic [WAY_IDX_W-1:0] tgt_w;
    logic [RANK_W-1:0]    lim;
    logic                 age_all;
    logic                 active;

    assign active = (i_kind != KIND_IGNORE);

    // Per-way status; way 0 is always in use
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            in_use[w] = (w == 0) || (w < int'(i_ways));
            match[w]  = in_use[w] && i_row[w].vld && (i_row[w].tag == i_tag);
            free[w]   = in_use[w] && !i_row[w].vld;
        end
    end

    // Lowest matching way and lowest free way
    always_comb begin
        any_hit  = 1'b0;
        any_free = 1'b0;
        hit_w    = '0;
        free_w   = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                any_hit = 1'b1;
                hit_w   = WAY_IDX_W'(w);
            end
            if (free[w]) begin
                any_free = 1'b1;
                free_w   = WAY_IDX_W'(w);
            end
        end
    end

    // Oldest way in use; ties go to the lowest index
    always_comb begin
        vic_w = '0;
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (in_use[w] && (i_row[w].rank > i_row[vic_w].rank)) begin
                vic_w = WAY_IDX_W'(w);
            end
        end
    end

    // Pick the way to touch and the aging rule
    always_comb begin
        priority if (any_hit) begin
            tgt_w   = hit_w;
            lim     = i_row[hit_w].rank;
            age_all = 1'b0;
        end else if (any_free) begin
            tgt_w   = free_w;
            lim     = '0;
            age_all = 1'b1;
        end else begin
            tgt_w   = vic_w;
            lim     = i_row[vic_w].rank;
            age_all = 1'b0;
        end
    end

    // New row: touched way is newest; younger ways age, all on a fill
    always_comb begin
        o_row = i_row;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WAY_IDX_W'(w) == tgt_w) begin
                o_row[w].vld  = 1'b1;
                o_row[w].tag  = i_tag;
                o_row[w].rank = '0;
            end else if (in_use[w] && i_row[w].vld && (age_all || (i_row[w].rank < lim))
                         && (i_row[w].rank < RANK_MAX)) begin
                o_row[w].rank = i_row[w].rank + RANK_W'(1);
            end
        end
    end

    // Verdict; a modify's second access always hits the line just touched
    always_comb begin
        o_res.wr_en      = active;
        o_res.second_hit = (i_kind == KIND_MODIFY);
        priority if (!active) begin
            o_res.outcome = OUT_IGNORED;
        end else if (any_hit) begin
            o_res.outcome = OUT_HIT;
        end else if (any_free) begin
            o_res.outcome = OUT_MISS;
        end else begin
            o_res.outcome = OUT_EVICT;
        end
    end

endmodule

`default_nettype wire

/* sv/set_assoc_lru_cache_sim_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_core
// Set-associative cache simulator with true LRU replacement and counters.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) takes one access per item: a kind
// (load, store, modify, ignored) and a 64-bit byte address. Output channel
// (o_out_valid / i_out_ready) returns one result per item: the outcome, the
// second-access hit flag of a modify and the running hit, miss and eviction
// counts after that item. Configuration (set bits, block bits, ways in use)
// is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write it
// only while the block idles, which the block does not enforce. The set's row
// is read into a register with the item when it is accepted; compare, LRU
// update and write back act as the item advances into the result register.
// Throughput is one item per cycle while the receiver takes results; a write
// to the set read in the same cycle is forwarded, so back-to-back accesses to
// one set need no gap. Reset clears the configuration to one way, zero set
// and block bits, clears the counters and the per-set valid bits; no clearing
// pass is needed, so an item can be taken in the first cycle after reset.
// When the receiver stalls the result holds, the item behind it waits in the
// lookup stage and further items are refused until the result is taken.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration
    input  wire logic                               i_cfg_we,
    input  wire logic [cslru_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [cslru_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // access items
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [cslru_pkg::KIND_W-1:0]       i_kind,
    input  wire logic [cslru_pkg::ADDR_W-1:0]       i_address,
    // result items
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [cslru_pkg::OUTCOME_W-1:0]         o_outcome,
    output logic                                    o_second_hit,
    output logic [cslru_pkg::COUNT_W-1:0]           o_hit_count,
    output logic [cslru_pkg::COUNT_W-1:0]           o_miss_count,
    output logic [cslru_pkg::COUNT_W-1:0]           o_eviction_count
);
    import cslru_pkg::*;

    // Configuration
    logic [SET_BITS_W-1:0]   r_set_bits;
    logic [BLOCK_BITS_W-1:0] r_block_bits;
    logic [WAYS_W-1:0]       r_ways;

    // Lookup stage
    logic                    r_in_vld;
    t_kind                   r_kind;
    logic [SET_IDX_W-1:0]    r_set;
    logic [TAG_W-1:0]        r_tag;

    // Result stage and counters
    logic                    r_out_vld;
    t_outcome                r_outcome;
    logic                    r_second_hit;
    logic [COUNT_W-1:0]      r_hits;
    logic [COUNT_W-1:0]      r_misses;
    logic [COUNT_W-1:0]      r_evicts;

    logic                    accept;
    logic                    advance;
    logic [SET_IDX_W-1:0]    in_set;
    logic [TAG_W-1:0]        in_tag;
    t_row                    cur_row;
    t_row                    new_row;
    t_lookup                 lookup;
    logic [1:0]              hit_inc;
    logic                    miss_inc;
    logic                    evict_inc;
    logic [COUNT_W-1:0]      n_hits;
    logic [COUNT_W-1:0]      n_misses;
    logic [COUNT_W-1:0]      n_evicts;

    // Handshake
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;
    assign accept     = i_in_valid && o_in_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= '0;
            r_block_bits <= '0;
            r_ways       <= WAYS_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SET_BITS:   r_set_bits   <= i_cfg_data[SET_BITS_W-1:0];
                CFG_BLOCK_BITS: r_block_bits <= i_cfg_data[BLOCK_BITS_W-1:0];
                CFG_WAYS:       r_ways       <= i_cfg_data[WAYS_W-1:0];
                default: ;
            endcase
        end
    end

    cslru_addr_split u_split (
        .i_address    (i_address),
        .i_set_bits   (r_set_bits),
        .i_block_bits (r_block_bits),
        .o_set        (in_set),
        .o_tag        (in_tag)
    );

    cslru_set_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (accept),
        .i_rd_set (in_set),
        .i_wr_en  (advance && lookup.wr_en),
        .i_wr_set (r_set),
        .i_wr_row (new_row),
        .o_row    (cur_row)
    );

    cslru_way_logic u_ways (
        .i_row  (cur_row),
        .i_tag  (r_tag),
        .i_ways (r_ways),
        .i_kind (r_kind),
        .o_row  (new_row),
        .o_res  (lookup)
    );

    // Lookup stage: hold the item while its row is read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= t_kind'(i_kind);
            r_set  <= in_set;
            r_tag  <= in_tag;
        end
    end

    // Counter updates; a modify adds its second hit
    assign hit_inc   = {1'b0, lookup.outcome == OUT_HIT} + {1'b0, lookup.second_hit};
    assign miss_inc  = (lookup.outcome == OUT_MISS) || (lookup.outcome == OUT_EVICT);
    assign evict_inc = (lookup.outcome == OUT_EVICT);
    assign n_hits    = r_hits + COUNT_W'(hit_inc);
    assign n_misses  = r_misses + COUNT_W'(miss_inc);
    assign n_evicts  = r_evicts + COUNT_W'(evict_inc);

    // Result stage and running counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_hits    <= '0;
            r_misses  <= '0;
            r_evicts  <= '0;
        end else begin
            if (advance) begin
                r_out_vld <= 1'b1;
                r_hits    <= n_hits;
                r_misses  <= n_misses;
                r_evicts  <= n_evicts;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_outcome    <= lookup.outcome;
            r_second_hit <= lookup.second_hit;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_outcome        = r_outcome;
    assign o_second_hit     = r_second_hit;
    assign o_hit_count      = r_hits;
    assign o_miss_count     = r_misses;
    assign o_eviction_count = r_evicts;

    // A result appears only when the lookup stage held an item
    a_out_from_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_in_vld))
        else $error("result appeared without an item in the lookup stage");

    // An ignored item leaves every counter unchanged
    a_ignored_keeps_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (lookup.outcome == OUT_IGNORED))
        |=> ($stable(r_hits) && $stable(r_misses) && $stable(r_evicts)))
        else $error("ignored item changed a counter");

    // An eviction bumps both the eviction and the miss counters by one
    a_evict_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (lookup.outcome == OUT_EVICT))
        |=> ((r_evicts == $past(r_evicts) + 32'd1) && (r_misses == $past(r_misses) + 32'd1)))
        else $error("eviction not counted");

    // A second hit only comes with a real access
    a_second_hit_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_second_hit) |-> (r_outcome != OUT_IGNORED))
        else $error("second hit reported for an ignored item");

endmodule

`default_nettype wire

/* sim/cache_lru_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cache_lru_checker
// Watches the access and result channels of the LRU cache simulator core,
// keeps its own copy of the cache store, configuration and counters, predicts
// the result of each accepted access item and compares it field by field
// with the result items in order.
// ----------------------------------------------------------------------------
module cache_lru_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [cslru_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [cslru_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                               i_in_valid,
    input  wire logic                               i_in_ready,
    input  wire logic [cslru_pkg::KIND_W-1:0]       i_kind,
    input  wire logic [cslru_pkg::ADDR_W-1:0]       i_address,
    input  wire logic                               i_out_valid,
    input  wire logic                               i_out_ready,
    input  wire logic [cslru_pkg::OUTCOME_W-1:0]    i_outcome,
    input  wire logic                               i_second_hit,
    input  wire logic [cslru_pkg::COUNT_W-1:0]      i_hit_count,
    input  wire logic [cslru_pkg::COUNT_W-1:0]      i_miss_count,
    input  wire logic [cslru_pkg::COUNT_W-1:0]      i_eviction_count,
    output int                                      o_fail_count,
    output int                                      o_pending
);
    import cslru_pkg::*;

    localparam int NUM_LINES = NUM_SETS * MAX_WAYS;

    typedef struct {
        t_outcome           outcome;
        logic               second_hit;
        logic [COUNT_W-1:0] hits;
        logic [COUNT_W-1:0] misses;
        logic [COUNT_W-1:0] evictions;
    } t_access_result;

    // Mirror of the configuration registers
    logic [SET_BITS_W-1:0]   set_bits_q;
    logic [BLOCK_BITS_W-1:0] block_bits_q;
    logic [WAYS_W-1:0]       ways_q;

    // Mirror of the cache store and the running counters
    bit                 line_vld  [NUM_LINES];
    logic [TAG_W-1:0]   line_tag  [NUM_LINES];
    logic [RANK_W-1:0]  line_rank [NUM_LINES];
    logic [COUNT_W-1:0] hits_q;
    logic [COUNT_W-1:0] misses_q;
    logic [COUNT_W-1:0] evictions_q;

    t_access_result results_due[$];
    t_access_result next_r;
    t_access_result head_r;
    int             fail_cnt;

    // Age one valid line: always, or only when younger than the limit
    function automatic void age_line(int idx, logic [RANK_W-1:0] lim, bit all);
        if (line_vld[idx] && (all || line_rank[idx] < lim) && line_rank[idx] < RANK_MAX)
            line_rank[idx] = line_rank[idx] + 1'b1;
    endfunction

    // One cache access: look up, update the LRU order and the counters
    function automatic t_outcome cache_access(logic [ADDR_W-1:0] addr);
        int               sb;
        int               bb;
        int               nw;
        int               shift;
        int               base;
        int               hit_way;
        int               free_way;
        int               victim;
        logic [ADDR_W-1:0] set_idx;
        logic [TAG_W-1:0]  tag;
        logic [RANK_W-1:0] lim;
        sb = (set_bits_q > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits_q);
        bb = (int'(block_bits_q) > 64 - sb) ? 64 - sb : int'(block_bits_q);
        nw = (ways_q == 0) ? 1 : ((ways_q > MAX_WAYS) ? MAX_WAYS : int'(ways_q));
        shift = sb + bb;
        set_idx = (bb < 64) ? ((addr >> bb) & ((64'd1 << sb) - 64'd1)) : '0;
        tag = (shift < 64) ? (addr >> shift) : '0;
        base = int'(set_idx) * MAX_WAYS;
        hit_way = -1;
        free_way = -1;
        for (int w = 0; w < nw; w++) begin
            if (hit_way < 0 && line_vld[base + w] && line_tag[base + w] == tag)
                hit_way = w;
            if (free_way < 0 && !line_vld[base + w])
                free_way = w;
        end
        // hit: promote the way, age those younger than it was
        if (hit_way >= 0) begin
            lim = line_rank[base + hit_way];
            for (int w = 0; w < nw; w++)
                if (w != hit_way)
                    age_line(base + w, lim, 1'b0);
            line_rank[base + hit_way] = '0;
            hits_q = hits_q + 1'b1;
            return OUT_HIT;
        end
        // miss into the lowest free way: age every valid way
        if (free_way >= 0) begin
            for (int w = 0; w < nw; w++)
                age_line(base + w, '0, 1'b1);
            line_vld[base + free_way]  = 1'b1;
            line_tag[base + free_way]  = tag;
            line_rank[base + free_way] = '0;
            misses_q = misses_q + 1'b1;
            return OUT_MISS;
        end
        // eviction: oldest rank loses, lowest way on a tie
        victim = 0;
        for (int w = 1; w < nw; w++)
            if (line_rank[base + w] > line_rank[base + victim])
                victim = w;
        lim = line_rank[base + victim];
        for (int w = 0; w < nw; w++)
            if (w != victim)
                age_line(base + w, lim, 1'b0);
        line_tag[base + victim]  = tag;
        line_rank[base + victim] = '0;
        misses_q    = misses_q + 1'b1;
        evictions_q = evictions_q + 1'b1;
        return OUT_EVICT;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            set_bits_q   = '0;
            block_bits_q = '0;
            ways_q       = WAYS_W'(1);
            for (int i = 0; i < NUM_LINES; i++) begin
                line_vld[i]  = 1'b0;
                line_tag[i]  = '0;
                line_rank[i] = '0;
            end
            hits_q      = '0;
            misses_q    = '0;
            evictions_q = '0;
            results_due.delete();
        end else begin
            // track register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SET_BITS:   set_bits_q   = i_cfg_data[SET_BITS_W-1:0];
                    CFG_BLOCK_BITS: block_bits_q = i_cfg_data[BLOCK_BITS_W-1:0];
                    CFG_WAYS:       ways_q       = i_cfg_data[WAYS_W-1:0];
                    default: ;
                endcase
            end
            // predict the result of an accepted access item
            if (i_in_valid && i_in_ready) begin
                next_r.second_hit = 1'b0;
                case (i_kind)
                    KIND_LOAD, KIND_STORE: begin
                        next_r.outcome = cache_access(i_address);
                    end
                    KIND_MODIFY: begin
                        next_r.outcome    = cache_access(i_address);
                        next_r.second_hit = (cache_access(i_address) == OUT_HIT);
                    end
                    default: begin
                        next_r.outcome = OUT_IGNORED;
                    end
                endcase
                next_r.hits      = hits_q;
                next_r.misses    = misses_q;
                next_r.evictions = evictions_q;
                results_due.push_back(next_r);
            end
            // compare an accepted result item with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $error("result item with no access item waiting");
                    fail_cnt++;
                end else begin
                    head_r = results_due.pop_front();
                    if (i_outcome != head_r.outcome) begin
                        $error("outcome: expected %0d, got %0d", head_r.outcome, i_outcome);
                        fail_cnt++;
                    end
                    if (i_second_hit != head_r.second_hit) begin
                        $error("second_hit: expected %0d, got %0d",
                               head_r.second_hit, i_second_hit);
                        fail_cnt++;
                    end
                    if (i_hit_count != head_r.hits) begin
                        $error("hit_count: expected %0d, got %0d", head_r.hits, i_hit_count);
                        fail_cnt++;
                    end
                    if (i_miss_count != head_r.misses) begin
                        $error("miss_count: expected %0d, got %0d",
                               head_r.misses, i_miss_count);
                        fail_cnt++;
                    end
                    if (i_eviction_count != head_r.evictions) begin
                        $error("eviction_count: expected %0d, got %0d",
                               head_r.evictions, i_eviction_count);
                        fail_cnt++;
                    end
                end
            end
        end
        o_pending    <= results_due.size();
        o_fail_count <= fail_cnt;
    end

    initial begin
        fail_cnt = 0;
    end

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the set-associative LRU cache simulator core.
// ----------------------------------------------------------------------------
// A short directed run under the reset configuration is followed by phases of
// random accesses, each under its own register setting and an idling pattern.
// Most random items reuse a small pool of tags on a few hot sets so that
// hits, fills and evictions all occur; the rest are fully random addresses.
// The checker beside the core predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_top;
    import cslru_pkg::*;

    localparam int NUM_PHASES  = 8;
    localparam int SETTLE_CYCS = 6;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [KIND_W-1:0]       i_kind;
    logic [ADDR_W-1:0]       i_address;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [OUTCOME_W-1:0]    o_outcome;
    logic                    o_second_hit;
    logic [COUNT_W-1:0]      o_hit_count;
    logic [COUNT_W-1:0]      o_miss_count;
    logic [COUNT_W-1:0]      o_eviction_count;

    int fail_count;
    int results_pending;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;

    // stimulus shaping state
    int                cfg_set;
    int                cfg_block;
    int                cfg_ways;
    int                eff_sb;
    int                eff_bb;
    int                eff_nw;
    int                phase_items;
    int                pool_n;
    int                pick;
    int                hot_set [2];
    logic [TAG_W-1:0]  tag_pool [10];
    logic [ADDR_W-1:0] rand_tag;
    logic [ADDR_W-1:0] rand_off;
    logic [ADDR_W-1:0] rand_addr;
    t_kind             rand_kind;

    set_assoc_lru_cache_sim_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_address        (i_address),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_outcome        (o_outcome),
        .o_second_hit     (o_second_hit),
        .o_hit_count      (o_hit_count),
        .o_miss_count     (o_miss_count),
        .o_eviction_count (o_eviction_count)
    );

    cache_lru_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_address        (i_address),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_outcome        (o_outcome),
        .i_second_hit     (o_second_hit),
        .i_hit_count      (o_hit_count),
        .i_miss_count     (o_miss_count),
        .i_eviction_count (o_eviction_count),
        .o_fail_count     (fail_count),
        .o_pending        (results_pending)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: stall at random according to the current idling pattern
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one access item and hold it until accepted
    task automatic send_access(input t_kind kind, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_address  <= addr;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // Hold off the sender until every result item has been taken
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCS) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(data);
        @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_SET_BITS;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_kind     <= KIND_LOAD;
        i_address  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: one way, whole address is the tag
        send_access(KIND_LOAD,   64'h0);
        send_access(KIND_LOAD,   64'h0);
        send_access(KIND_LOAD,   64'h0000_0001_0000_0000);
        send_access(KIND_LOAD,   64'h0);
        send_access(KIND_STORE,  64'hFFFF_FFFF_FFFF_FFFF);
        send_access(KIND_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(KIND_MODIFY, 64'h5555_5555_5555_5555);
        send_access(KIND_IGNORE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(KIND_IGNORE, 64'h0);
        send_access(KIND_STORE,  64'hAAAA_AAAA_AAAA_AAAA);
        send_access(KIND_MODIFY, 64'h8000_0000_0000_0000);
        send_access(KIND_LOAD,   64'h8000_0000_0000_0001);
        send_access(KIND_STORE,  64'h8000_0000_0000_0001);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // register setting and idling pattern of this phase
            case (ph)
                0: begin cfg_set = 2; cfg_block = 4;  cfg_ways = 4;  end
                1: begin cfg_set = 7; cfg_block = 63; cfg_ways = 8;  end
                2: begin cfg_set = 0; cfg_block = 0;  cfg_ways = 0;  end
                3: begin cfg_set = 6; cfg_block = 32; cfg_ways = 15; end
                4: begin cfg_set = 3; cfg_block = 6;  cfg_ways = 8;  end
                5: begin cfg_set = 1; cfg_block = 2;  cfg_ways = 2;  end
                6: begin cfg_set = 4; cfg_block = 5;  cfg_ways = 6;  end
                default: begin cfg_set = 5; cfg_block = 0; cfg_ways = 3; end
            endcase
            phase_items = (ph == 3) ? 200 : 170;

            wait_drained();
            write_reg(CFG_SET_BITS,   cfg_set);
            write_reg(CFG_BLOCK_BITS, cfg_block);
            write_reg(CFG_WAYS,       cfg_ways);
            i_cfg_we <= 1'b0;
            @(posedge i_clk);

            case (ph % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 65; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 65; end
                default: begin send_gap_pct = 38; recv_stall_pct = 38; end
            endcase

            // effective geometry, for shaping addresses
            eff_sb = (cfg_set > MAX_SET_BITS) ? MAX_SET_BITS : cfg_set;
            eff_bb = (cfg_block > 64 - eff_sb) ? 64 - eff_sb : cfg_block;
            eff_nw = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_WAYS) ? MAX_WAYS : cfg_ways);

            // a few hot sets and slightly more tags than ways
            pool_n = eff_nw + 2;
            for (int i = 0; i < 2; i++)
                hot_set[i] = $urandom_range((1 << eff_sb) - 1);
            for (int i = 0; i < pool_n; i++)
                tag_pool[i] = {$urandom, $urandom};

            for (int n = 0; n < phase_items; n++) begin
                // pause mid-phase until the core has drained
                if (n == phase_items / 2)
                    wait_drained();
                if ($urandom_range(99) < 80) begin
                    pick      = $urandom_range(9);
                    rand_kind = (pick == 9) ? KIND_IGNORE : t_kind'(pick / 3);
                    rand_tag  = tag_pool[$urandom_range(pool_n - 1)];
                    rand_off  = {$urandom, $urandom};
                    rand_addr = ((eff_sb + eff_bb < 64) ? (rand_tag << (eff_sb + eff_bb)) : '0)
                              | (ADDR_W'(hot_set[$urandom_range(1)]) << eff_bb)
                              | (rand_off & ((64'd1 << eff_bb) - 64'd1));
                end else begin
                    rand_kind = t_kind'($urandom_range(3));
                    rand_addr = {$urandom, $urandom};
                end
                send_access(rand_kind, rand_addr);
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("set_assoc_lru_cache_sim_core verification clean");
        end else begin
            $display("set_assoc_lru_cache_sim_core verification failed");
        end
        $finish;
    end

    // Timeout
    initial begin
        #1000000;
        $display("set_assoc_lru_cache_sim_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire
